[hw/rtl/hsm_pkg.sv]
// Shared types, codes and helper functions of the two-wire humidity sensor master.
// No dependencies; every other file of the block imports this package.

package hsm_pkg;

  localparam int RESET_CLOCKS_DEF = 9;
  localparam int WAIT_WIDTH_DEF   = 16;

  localparam int CMD_W   = 3;
  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 16;
  localparam int ERR_W   = 2;
  localparam int DUR_W   = 10;
  localparam int LIMIT_W = 16;

  // commands taken in idle
  localparam logic [CMD_W-1:0] CMD_NONE       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TEMP       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_HUMID      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RD_STATUS  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WR_STATUS  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SOFT_RESET = 3'd5;
  localparam logic [CMD_W-1:0] CMD_LINK_RESET = 3'd6;

  // sensor opcodes
  localparam logic [BYTE_W-1:0] OP_MEAS_TEMP  = 8'h03;
  localparam logic [BYTE_W-1:0] OP_MEAS_HUMID = 8'h05;
  localparam logic [BYTE_W-1:0] OP_RD_STATUS  = 8'h07;
  localparam logic [BYTE_W-1:0] OP_WR_STATUS  = 8'h06;
  localparam logic [BYTE_W-1:0] OP_SOFT_RESET = 8'h1e;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_GAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LIMIT = 2'd2;

  localparam logic [DUR_W-1:0]   CLOCK_HIGH_RST = 10'd15;
  localparam logic [DUR_W-1:0]   EDGE_GAP_RST   = 10'd5;
  localparam logic [LIMIT_W-1:0] WAIT_LIMIT_RST = 16'hffff;

  typedef struct packed {
    logic [DUR_W-1:0]   clock_high;
    logic [DUR_W-1:0]   edge_gap;
    logic [LIMIT_W-1:0] wait_limit;
  } cfg_t;

  typedef struct packed {
    logic               clock_out;
    logic               data_pull_low;
    logic               busy_res;
    logic               done_res;
    logic [VALUE_W-1:0] value_out;
    logic [BYTE_W-1:0]  checksum;
    logic [ERR_W-1:0]   error_count;
  } result_t;

  function automatic logic [BYTE_W-1:0] opcode(input logic [CMD_W-1:0] cmd);
    logic [BYTE_W-1:0] op;
    op = '0;
    unique case (cmd)
      CMD_TEMP:       op = OP_MEAS_TEMP;
      CMD_HUMID:      op = OP_MEAS_HUMID;
      CMD_RD_STATUS:  op = OP_RD_STATUS;
      CMD_WR_STATUS:  op = OP_WR_STATUS;
      CMD_SOFT_RESET: op = OP_SOFT_RESET;
      default:        op = '0;
    endcase
    return op;
  endfunction

  // bytes read back: status + checksum, or msb + lsb + checksum
  function automatic logic [1:0] read_count(input logic [CMD_W-1:0] cmd);
    return (cmd == CMD_RD_STATUS) ? 2'd2 : 2'd3;
  endfunction

endpackage

[hw/rtl/hsm_ifs.sv]
// Valid/ready channel interfaces of the humidity sensor master: tick words in,
// result words out, configuration writes. Depends on hsm_pkg.

interface hsm_req_if import hsm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [BYTE_W-1:0] write_data;
  logic              data_pin;

  modport source(output valid, cmd, write_data, data_pin, input ready);
  modport sink(input valid, cmd, write_data, data_pin, output ready);
endinterface

interface hsm_rsp_if import hsm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               clock_out;
  logic               data_pull_low;
  logic               busy_res;
  logic               done_res;
  logic [VALUE_W-1:0] value_out;
  logic [BYTE_W-1:0]  checksum;
  logic [ERR_W-1:0]   error_count;

  modport source(output valid, clock_out, data_pull_low, busy_res, done_res, value_out,
                 checksum, error_count, input ready);
  modport sink(input valid, clock_out, data_pull_low, busy_res, done_res, value_out,
               checksum, error_count, output ready);
endinterface

interface hsm_cfg_if import hsm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[hw/rtl/hsm_cfg_regs.sv]
// Configuration registers of the humidity sensor master (bit timing, ready wait limit).
// Depends on hsm_pkg and hsm_cfg_if.

module hsm_cfg_regs import hsm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  hsm_cfg_if.sink   cfg,
  output cfg_t      regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.clock_high <= CLOCK_HIGH_RST;
      regs.edge_gap   <= EDGE_GAP_RST;
      regs.wait_limit <= WAIT_LIMIT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_CLOCK_HIGH: regs.clock_high <= cfg.data[DUR_W-1:0];
        CFG_EDGE_GAP:   regs.edge_gap   <= cfg.data[DUR_W-1:0];
        CFG_WAIT_LIMIT: regs.wait_limit <= cfg.data[LIMIT_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

endmodule

[hw/rtl/hsm_core.sv]
// Sequencer of the humidity sensor master: phase machine, counters, shift byte and
// result registers, advanced once per accepted tick word. Depends on hsm_pkg.

module hsm_core import hsm_pkg::*; #(
  parameter int RESET_CLOCKS = RESET_CLOCKS_DEF,
  parameter int WAIT_WIDTH   = WAIT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [BYTE_W-1:0] write_data,
  input  logic              data_pin,
  input  cfg_t              cfg,
  output result_t           res
);

  localparam int TICK_W = (WAIT_WIDTH > DUR_W) ? WAIT_WIDTH : DUR_W;
  localparam int CMP_W  = (TICK_W > LIMIT_W) ? TICK_W : LIMIT_W;
  localparam logic [TICK_W-1:0] WAIT_ALL_ONES = TICK_W'((64'd1 << WAIT_WIDTH) - 64'd1);

  typedef enum logic [17:0] {
    PH_IDLE  = 18'h00001,
    PH_RST_LO = 18'h00002,
    PH_RST_HI = 18'h00004,
    PH_S_A   = 18'h00008,
    PH_S_B   = 18'h00010,
    PH_S_C   = 18'h00020,
    PH_S_D   = 18'h00040,
    PH_S_E   = 18'h00080,
    PH_S_F   = 18'h00100,
    PH_WR_LO = 18'h00200,
    PH_WR_HI = 18'h00400,
    PH_WA_LO = 18'h00800,
    PH_WA_HI = 18'h01000,
    PH_WAIT  = 18'h02000,
    PH_RD_LO = 18'h04000,
    PH_RD_HI = 18'h08000,
    PH_RK_LO = 18'h10000,
    PH_RK_HI = 18'h20000
  } phase_t;

  phase_t              phase, phase_next;
  logic [CMD_W-1:0]    active_cmd, active_cmd_next;
  logic [3:0]          bit_cnt, bit_cnt_next;
  logic [1:0]          byte_cnt, byte_cnt_next;
  logic [TICK_W-1:0]   tick, tick_next;
  logic [BYTE_W-1:0]   shift, shift_next;
  logic [VALUE_W-1:0]  value, value_next;
  logic [BYTE_W-1:0]   checksum, checksum_next;
  logic [ERR_W-1:0]    error, error_next;
  logic                done_next;

  logic [TICK_W-1:0]   tick_inc;
  logic [DUR_W-1:0]    dur;
  logic                high_phase;
  logic                expired;
  logic                timeout;
  logic [3:0]          bit_inc;
  logic [1:0]          byte_inc;
  logic [BYTE_W-1:0]   rx_byte;
  logic [ERR_W-1:0]    error_inc;

  assign high_phase = (phase == PH_S_D) || (phase == PH_WR_HI) || (phase == PH_WA_HI) ||
                      (phase == PH_RD_HI) || (phase == PH_RK_HI);
  assign tick_inc   = tick + 1'b1;
  assign bit_inc    = bit_cnt + 1'b1;
  assign byte_inc   = byte_cnt + 1'b1;
  assign rx_byte    = {shift[BYTE_W-2:0], data_pin};
  assign error_inc  = (error == 2'd3) ? error : error + 1'b1;

  always_comb begin
    dur = high_phase ? cfg.clock_high : cfg.edge_gap;
    if (dur == '0) begin
      dur = DUR_W'(1);
    end
  end

  assign expired = (tick_inc >= TICK_W'(dur));
  assign timeout = (CMP_W'(tick_inc) >= CMP_W'(cfg.wait_limit)) || (tick_inc == WAIT_ALL_ONES);

  always_comb begin
    phase_next      = phase;
    active_cmd_next = active_cmd;
    bit_cnt_next    = bit_cnt;
    byte_cnt_next   = byte_cnt;
    tick_next       = tick;
    shift_next      = shift;
    value_next      = value;
    checksum_next   = checksum;
    error_next      = error;
    done_next       = 1'b0;

    if (phase == PH_IDLE) begin
      if (cmd != CMD_NONE && cmd <= CMD_LINK_RESET) begin
        active_cmd_next = cmd;
        error_next      = '0;
        bit_cnt_next    = '0;
        byte_cnt_next   = '0;
        tick_next       = '0;
        if (cmd == CMD_WR_STATUS) begin
          value_next = VALUE_W'(write_data);
        end
        phase_next = (cmd >= CMD_SOFT_RESET) ? PH_RST_LO : PH_S_A;
      end
    end else if (phase == PH_WAIT) begin
      if (!data_pin || timeout) begin
        if (data_pin) begin
          error_next = error_inc;
        end
        byte_cnt_next = '0;
        bit_cnt_next  = '0;
        tick_next     = '0;
        phase_next    = PH_RD_LO;
      end else begin
        tick_next = tick_inc;
      end
    end else begin
      tick_next = tick_inc;
      if (expired) begin
        tick_next = '0;
        unique case (phase)
          PH_RST_LO: phase_next = PH_RST_HI;
          PH_RST_HI: begin
            if (int'(bit_cnt) + 1 >= RESET_CLOCKS) begin
              bit_cnt_next = '0;
              phase_next   = PH_S_A;
            end else begin
              bit_cnt_next = bit_inc;
              phase_next   = PH_RST_LO;
            end
          end
          PH_S_A: phase_next = PH_S_B;
          PH_S_B: phase_next = PH_S_C;
          PH_S_C: phase_next = PH_S_D;
          PH_S_D: phase_next = PH_S_E;
          PH_S_E: phase_next = PH_S_F;
          PH_S_F: begin
            if (active_cmd == CMD_LINK_RESET) begin
              phase_next = PH_IDLE;
              done_next  = 1'b1;
            end else begin
              shift_next    = opcode(active_cmd);
              byte_cnt_next = '0;
              bit_cnt_next  = '0;
              phase_next    = PH_WR_LO;
            end
          end
          PH_WR_LO: phase_next = PH_WR_HI;
          PH_WR_HI: begin
            shift_next = {shift[BYTE_W-2:0], 1'b0};
            if (bit_inc >= 4'd8) begin
              bit_cnt_next = '0;
              phase_next   = PH_WA_LO;
            end else begin
              bit_cnt_next = bit_inc;
              phase_next   = PH_WR_LO;
            end
          end
          PH_WA_LO: phase_next = PH_WA_HI;
          PH_WA_HI: begin
            if (data_pin) begin
              error_next = error_inc;  // no acknowledge
            end
            if (active_cmd == CMD_TEMP || active_cmd == CMD_HUMID) begin
              phase_next = PH_WAIT;
            end else if (active_cmd == CMD_RD_STATUS) begin
              byte_cnt_next = '0;
              bit_cnt_next  = '0;
              phase_next    = PH_RD_LO;
            end else if (active_cmd == CMD_WR_STATUS && byte_cnt == 2'd0) begin
              byte_cnt_next = 2'd1;
              shift_next    = value[BYTE_W-1:0];
              bit_cnt_next  = '0;
              phase_next    = PH_WR_LO;
            end else begin
              phase_next = PH_IDLE;
              done_next  = 1'b1;
            end
          end
          PH_RD_LO: phase_next = PH_RD_HI;
          PH_RD_HI: begin
            shift_next = rx_byte;
            if (bit_inc >= 4'd8) begin
              if (active_cmd == CMD_RD_STATUS) begin
                if (byte_cnt == 2'd0) begin
                  value_next = VALUE_W'(rx_byte);
                end else begin
                  checksum_next = rx_byte;
                end
              end else if (byte_cnt == 2'd0) begin
                value_next = {rx_byte, value[BYTE_W-1:0]};
                value_next[BYTE_W-1:0] = '0;
              end else if (byte_cnt == 2'd1) begin
                value_next = {value[VALUE_W-1:BYTE_W], rx_byte};
              end else begin
                checksum_next = rx_byte;
              end
              bit_cnt_next = '0;
              phase_next   = PH_RK_LO;
            end else begin
              bit_cnt_next = bit_inc;
              phase_next   = PH_RD_LO;
            end
          end
          PH_RK_LO: phase_next = PH_RK_HI;
          PH_RK_HI: begin
            byte_cnt_next = byte_inc;
            if (byte_inc >= read_count(active_cmd)) begin
              phase_next = PH_IDLE;
              done_next  = 1'b1;
            end else begin
              bit_cnt_next = '0;
              phase_next   = PH_RD_LO;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // line levels after this tick
  always_comb begin
    res.clock_out = (phase_next == PH_RST_HI) || (phase_next == PH_S_B) ||
                    (phase_next == PH_S_C) || (phase_next == PH_S_E) ||
                    (phase_next == PH_S_F) || (phase_next == PH_WR_HI) ||
                    (phase_next == PH_WA_HI) || (phase_next == PH_RD_HI) ||
                    (phase_next == PH_RK_HI);
    res.data_pull_low = (phase_next == PH_S_C) || (phase_next == PH_S_D) ||
                        (phase_next == PH_S_E) ||
                        (((phase_next == PH_WR_LO) || (phase_next == PH_WR_HI)) &&
                         !shift_next[BYTE_W-1]) ||
                        (((phase_next == PH_RK_LO) || (phase_next == PH_RK_HI)) &&
                         ({1'b0, byte_cnt_next} + 3'd1 < {1'b0, read_count(active_cmd_next)}));
    res.busy_res    = (phase_next != PH_IDLE);
    res.done_res    = done_next;
    res.value_out   = value_next;
    res.checksum    = checksum_next;
    res.error_count = error_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      active_cmd <= CMD_NONE;
      bit_cnt    <= '0;
      byte_cnt   <= '0;
      tick       <= '0;
      shift      <= '0;
      value      <= '0;
      checksum   <= '0;
      error      <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      active_cmd <= active_cmd_next;
      bit_cnt    <= bit_cnt_next;
      byte_cnt   <= byte_cnt_next;
      tick       <= tick_next;
      shift      <= shift_next;
      value      <= value_next;
      checksum   <= checksum_next;
      error      <= error_next;
    end
  end

endmodule

[hw/rtl/hsm_rsp_reg.sv]
// Result register of the humidity sensor master: holds one result word for the
// response channel and gives the request side its ready. Depends on hsm_pkg, hsm_rsp_if.

module hsm_rsp_reg import hsm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  result_t   res,
  output logic      in_ready,
  hsm_rsp_if.source rsp
);

  logic    valid;
  result_t data;

  assign in_ready = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data <= res;
    end
  end

  assign rsp.valid         = valid;
  assign rsp.clock_out     = data.clock_out;
  assign rsp.data_pull_low = data.data_pull_low;
  assign rsp.busy_res      = data.busy_res;
  assign rsp.done_res      = data.done_res;
  assign rsp.value_out     = data.value_out;
  assign rsp.checksum      = data.checksum;
  assign rsp.error_count   = data.error_count;

endmodule

[hw/rtl/humidity_sensor_two_wire_master.sv]
// Top level of the two-wire humidity/temperature sensor master.
// Depends on hsm_pkg, hsm_ifs, hsm_cfg_regs, hsm_core, hsm_rsp_reg.

// Each request word is one timing tick: it carries a command (taken only when idle),
// the status byte for a write-status command and the sampled level of the data line.
// Each tick yields exactly one response word with the clock and data-pull levels to
// drive for that tick, busy, a one-tick done pulse, the last value, checksum and error
// count. One word is accepted every clock cycle while no held result blocks it; the
// sequencer works on a word in the cycle it is accepted and the result lands in the
// result register at that edge, so its response is offered on the cycle after
// acceptance. The request channel is ready whenever the result register is empty or
// being read in the same cycle. Configuration writes are accepted every cycle and set
// bit timing (clock high and edge gap, in ticks) and the ready wait limit.

module humidity_sensor_two_wire_master import hsm_pkg::*; #(
  parameter int RESET_CLOCKS = RESET_CLOCKS_DEF,
  parameter int WAIT_WIDTH   = WAIT_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  hsm_req_if.sink   req,
  hsm_rsp_if.source rsp,
  hsm_cfg_if.sink   cfg
);

  cfg_t    cfg_regs;
  result_t res;
  logic    in_ready;
  logic    accept;

  assign req.ready = in_ready;
  assign accept    = req.valid && in_ready;

  hsm_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_regs)
  );

  hsm_core #(
    .RESET_CLOCKS (RESET_CLOCKS),
    .WAIT_WIDTH   (WAIT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cmd        (req.cmd),
    .write_data (req.write_data),
    .data_pin   (req.data_pin),
    .cfg        (cfg_regs),
    .res        (res)
  );

  hsm_rsp_reg u_rsp (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .res      (res),
    .in_ready (in_ready),
    .rsp      (rsp)
  );

  // a held result must block new ticks
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !req.ready)
    else $error("request accepted while result word is held");

  // done ends a sequence: lines idle in the same word
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.done_res) |-> (!rsp.busy_res && !rsp.clock_out && !rsp.data_pull_low))
    else $error("done word with active bus");

  a_idle_lines: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.busy_res) |-> (!rsp.clock_out && !rsp.data_pull_low))
    else $error("bus driven while idle");

  a_err_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.error_count != 2'd3))
    else $error("error count beyond two");

endmodule
